FILE: design/abtsl_pkg.sv
// Shared types, widths, constants and band range tables for the band to strip level block.
// Depends on nothing; every other file of the block imports it.
package abtsl_pkg;

    localparam int BAND_COUNT     = 7;
    localparam int STRIP_W        = 7;
    localparam int LEVEL_W        = 8;
    localparam int NUM_STRIPS_W   = 7;
    localparam int LEDS_W         = 11;
    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 11;
    localparam int IN_DATA_W      = 64;
    localparam int NUM_W          = 10;
    localparam int DIV_W          = 7;
    localparam int REM_W          = 15;
    localparam int QUOT_W         = 8;
    localparam int MAX_STRIPS_DEF = 64;
    // Input register, lanes, merge, products, sum and eight divider steps.
    localparam int PIPE_DEPTH     = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_STRIPS     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_LEDS_PER_STRIP = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_MAX,
        MODE_INTERP
    } mode_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] band;
        logic [LEVEL_W-1:0] masked;
        logic [NUM_W-1:0]   diff;
        logic               ge;
    } lane_t;

    typedef struct packed {
        logic               use_div;
        logic [LEVEL_W-1:0] fixed_level;
        logic [LEVEL_W-1:0] band_lo;
        logic [LEVEL_W-1:0] band_hi;
        logic [DIV_W-1:0]   rem;
        logic [DIV_W-1:0]   divisor;
    } merge_t;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [DIV_W-1:0]   divisor;
        logic [QUOT_W-1:0]  quot;
        logic               use_div;
        logic [LEVEL_W-1:0] fixed_level;
    } div_t;

    // Row is the strip count minus one, column the strip. Unused entries are zero.
    localparam logic [2:0] BAND_LO_TBL [0:7][0:7] = '{
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd2, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd2, 3'd4, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd0},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
    };

    localparam logic [2:0] BAND_HI_TBL [0:7][0:7] = '{
        '{3'd6, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd3, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd1, 3'd4, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd1, 3'd3, 3'd5, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd1, 3'd2, 3'd3, 3'd4, 3'd6, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd6, 3'd0, 3'd0},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
    };

endpackage

FILE: design/audio_band_to_strip_level_top.sv
// Top level of the band to strip level block: configuration registers, pipeline control,
// lanes, merge, products and the divider chain. Depends on abtsl_pkg and all abtsl_ modules.
//
//   channel   direction  handshake               payload
//   s_        in         s_tvalid / s_tready     s_tdata: strip index and seven band levels
//   m_        out        m_tvalid / m_tready     m_tdata: strip level
//   cfg_      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One query is accepted per clock cycle while the output is not stalled. The pipeline has
// thirteen register stages: the input register, the lanes, the merge, the products, the sum
// and the eight single-bit steps of the interpolation divider.
// All stages advance together on one enable; when a result waits at the output and
// m_tready is low, the whole pipeline holds and s_tready drops in the same cycle.
// rst_n clears the stage valid bits and sets both configuration registers to one.
// The configuration channel is always ready.
module audio_band_to_strip_level_top #(
    parameter int MAX_STRIPS = abtsl_pkg::MAX_STRIPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [6:0] strip_index, [14:7] band_level_0, [22:15] band_level_1, [30:23] band_level_2,
    // [38:31] band_level_3, [46:39] band_level_4, [54:47] band_level_5,
    // [62:55] band_level_6, [63] zero fill
    input  logic [abtsl_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] strip_level
    output logic [abtsl_pkg::LEVEL_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [abtsl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [abtsl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import abtsl_pkg::*;

    localparam int DIV_STEPS = QUOT_W;
    // Strip counts above MAX_STRIPS saturate to it.
    localparam logic [NUM_STRIPS_W-1:0] N_CAP =
        (MAX_STRIPS >= (1 << NUM_STRIPS_W) - 1) ? {NUM_STRIPS_W{1'b1}}
                                                 : NUM_STRIPS_W'(MAX_STRIPS);

    // Configuration registers.
    logic [NUM_STRIPS_W-1:0] num_strips_reg;
    logic [LEDS_W-1:0]       leds_per_strip_reg;

    // Pipeline control.
    logic en;

    // Query decode, before the input register.
    logic [STRIP_W-1:0]      strip_in;
    logic [LEVEL_W-1:0]      band_in [BAND_COUNT];
    logic [NUM_STRIPS_W-1:0] n_eff;
    logic                    is_zero;
    mode_t                   mode_next;
    logic [2:0]              tbl_row;
    logic [2:0]              tbl_col;
    logic [NUM_W-1:0]        num_next;

    // First stage registers.
    logic                    valid_s1_reg;
    mode_t                   mode_s1_reg;
    logic [NUM_W-1:0]        num_s1_reg;
    logic [DIV_W-1:0]        d_s1_reg;
    logic [2:0]              lo_s1_reg;
    logic [2:0]              hi_s1_reg;
    logic [LEVEL_W-1:0]      band_s1_reg [BAND_COUNT];

    // Lane stage.
    lane_t                   lane_res [BAND_COUNT];
    logic                    valid_s2_reg;
    mode_t                   mode_s2_reg;
    logic [DIV_W-1:0]        d_s2_reg;

    // Merge stage.
    merge_t                  merge_s3;
    logic                    valid_s3_reg;

    // Products of the interpolation weights.
    logic [DIV_W-1:0]        d_minus_r;
    logic [REM_W-1:0]        p0_next;
    logic [REM_W-1:0]        p1_next;
    logic [REM_W-1:0]        p0_reg;
    logic [REM_W-1:0]        p1_reg;
    logic                    valid_s4_reg;
    logic                    use_div_s4_reg;
    logic [LEVEL_W-1:0]      fixed_s4_reg;
    logic [DIV_W-1:0]        d_s4_reg;

    // Sum feeding the divider.
    div_t                    div_s5_next;
    div_t                    div_s5_reg;
    logic                    valid_s5_reg;

    // Divider chain.
    div_t                    div_chain [DIV_STEPS+1];
    logic                    valid_chain [DIV_STEPS+1];

    // ---------------------------------------------------------------------------------------
    // Configuration writes; unknown indexes are ignored.
    // ---------------------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_strips_reg     <= NUM_STRIPS_W'(1);
            leds_per_strip_reg <= LEDS_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NUM_STRIPS:
                begin
                    num_strips_reg <= cfg_data[NUM_STRIPS_W-1:0];
                end
                REG_LEDS_PER_STRIP:
                begin
                    leds_per_strip_reg <= cfg_data[LEDS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------------------------
    // Global stall: everything moves when the output slot is free or being emptied.
    // ---------------------------------------------------------------------------------------
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------------------------------------------------------------------------------
    // Query decode. The mode is fixed here: disabled, zero LEDs or out of range gives zero,
    // up to seven strips takes the maximum over a table range, more strips interpolate.
    // ---------------------------------------------------------------------------------------
    assign strip_in = s_tdata[STRIP_W-1:0];

    for (genvar k = 0; k < BAND_COUNT; k++)
    begin : g_unpack
        assign band_in[k] = s_tdata[STRIP_W + k*LEVEL_W +: LEVEL_W];
    end

    assign n_eff   = (num_strips_reg > N_CAP) ? N_CAP : num_strips_reg;
    assign is_zero = (n_eff == '0) || (leds_per_strip_reg == '0) || (strip_in >= n_eff);

    always_comb
    begin
        priority if (is_zero)
        begin
            mode_next = MODE_ZERO;
        end
        else if (n_eff <= NUM_STRIPS_W'(BAND_COUNT))
        begin
            mode_next = MODE_MAX;
        end
        else
        begin
            mode_next = MODE_INTERP;
        end
    end

    // The table index only matters in the maximum mode, where both values fit three bits.
    assign tbl_row  = 3'(n_eff - NUM_STRIPS_W'(1));
    assign tbl_col  = strip_in[2:0];
    // Scaled position strip * 6 along the band axis.
    assign num_next = ({3'b000, strip_in} << 2) + ({3'b000, strip_in} << 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_s1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_s1_reg <= mode_next;
            num_s1_reg  <= num_next;
            d_s1_reg    <= DIV_W'(n_eff - NUM_STRIPS_W'(1));
            lo_s1_reg   <= BAND_LO_TBL[tbl_row][tbl_col];
            hi_s1_reg   <= BAND_HI_TBL[tbl_row][tbl_col];
            for (int k = 0; k < BAND_COUNT; k++)
            begin
                band_s1_reg[k] <= band_in[k];
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // Seven lanes, one per band. Each masks its band against the strip's range and tests
    // one candidate quotient of strip * 6 / (strips - 1).
    // ---------------------------------------------------------------------------------------
    for (genvar k = 0; k < BAND_COUNT; k++)
    begin : g_lane
        abtsl_lane #(
            .LANE (k)
        ) u_lane (
            .clk      (clk),
            .en       (en),
            .band     (band_s1_reg[k]),
            .range_lo (lo_s1_reg),
            .range_hi (hi_s1_reg),
            .num      (num_s1_reg),
            .divisor  (d_s1_reg),
            .lane_out (lane_res[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s2_reg <= 1'b0;
            valid_s3_reg <= 1'b0;
            valid_s4_reg <= 1'b0;
            valid_s5_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_s2_reg <= valid_s1_reg;
            valid_s3_reg <= valid_s2_reg;
            valid_s4_reg <= valid_s3_reg;
            valid_s5_reg <= valid_s4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_s2_reg <= mode_s1_reg;
            d_s2_reg    <= d_s1_reg;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Merge: the lanes' findings become one fixed level or one division job.
    // ---------------------------------------------------------------------------------------
    abtsl_merge u_merge (
        .clk       (clk),
        .en        (en),
        .lanes     (lane_res),
        .mode      (mode_s2_reg),
        .divisor   (d_s2_reg),
        .merge_out (merge_s3)
    );

    // ---------------------------------------------------------------------------------------
    // Interpolation weights: band[q] * (d - r) and band[q+1] * r.
    // ---------------------------------------------------------------------------------------
    assign d_minus_r = merge_s3.divisor - merge_s3.rem;
    assign p0_next   = {{(REM_W-LEVEL_W){1'b0}}, merge_s3.band_lo}
                     * {{(REM_W-DIV_W){1'b0}}, d_minus_r};
    assign p1_next   = {{(REM_W-LEVEL_W){1'b0}}, merge_s3.band_hi}
                     * {{(REM_W-DIV_W){1'b0}}, merge_s3.rem};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg         <= p0_next;
            p1_reg         <= p1_next;
            use_div_s4_reg <= merge_s3.use_div;
            fixed_s4_reg   <= merge_s3.fixed_level;
            d_s4_reg       <= merge_s3.divisor;
        end
    end

    // The weighted sum never exceeds 255 times the divisor, so the quotient fits eight bits.
    always_comb
    begin
        div_s5_next.rem         = p0_reg + p1_reg;
        div_s5_next.divisor     = d_s4_reg;
        div_s5_next.quot        = '0;
        div_s5_next.use_div     = use_div_s4_reg;
        div_s5_next.fixed_level = fixed_s4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_s5_reg <= div_s5_next;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Restoring divider, most significant quotient bit first.
    // ---------------------------------------------------------------------------------------
    assign div_chain[0]   = div_s5_reg;
    assign valid_chain[0] = valid_s5_reg;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        abtsl_div_stage #(
            .BIT (DIV_STEPS - 1 - i)
        ) u_div_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_chain[i]),
            .div_in    (div_chain[i]),
            .out_valid (valid_chain[i+1]),
            .div_out   (div_chain[i+1])
        );
    end

    // The last divider step doubles as the output register.
    assign m_tvalid = valid_chain[DIV_STEPS];
    assign m_tdata  = div_chain[DIV_STEPS].use_div ? div_chain[DIV_STEPS].quot
                                                   : div_chain[DIV_STEPS].fixed_level;

endmodule

FILE: design/abtsl_lane.sv
// One band lane: range mask for the maximum path and one quotient trial for the interpolation path.
// Depends on abtsl_pkg.
module abtsl_lane #(
    parameter int LANE = 0
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [abtsl_pkg::LEVEL_W-1:0] band,
    input  logic [2:0]                 range_lo,
    input  logic [2:0]                 range_hi,
    input  logic [abtsl_pkg::NUM_W-1:0]   num,
    input  logic [abtsl_pkg::DIV_W-1:0]   divisor,
    output abtsl_pkg::lane_t           lane_out
);
    import abtsl_pkg::*;

    localparam logic [2:0] LANE_IDX = 3'(LANE);

    logic [NUM_W-1:0] multiple;
    lane_t            lane_next;
    lane_t            lane_reg;

    // This lane tests whether the scaled position reaches LANE whole divisors.
    assign multiple = NUM_W'(LANE) * {{(NUM_W-DIV_W){1'b0}}, divisor};

    always_comb
    begin
        lane_next.band   = band;
        lane_next.masked = (LANE_IDX >= range_lo && LANE_IDX <= range_hi) ? band : '0;
        lane_next.diff   = num - multiple;
        lane_next.ge     = (num >= multiple);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

FILE: design/abtsl_merge.sv
// Merge stage: maximum over the masked lanes, quotient selection and neighbor band pick.
// Depends on abtsl_pkg.
module abtsl_merge (
    input  logic                       clk,
    input  logic                       en,
    input  abtsl_pkg::lane_t           lanes [abtsl_pkg::BAND_COUNT],
    input  abtsl_pkg::mode_t           mode,
    input  logic [abtsl_pkg::DIV_W-1:0]   divisor,
    output abtsl_pkg::merge_t          merge_out
);
    import abtsl_pkg::*;

    logic [BAND_COUNT-2:0] sel;
    logic [LEVEL_W-1:0]    m01;
    logic [LEVEL_W-1:0]    m23;
    logic [LEVEL_W-1:0]    m45;
    logic [LEVEL_W-1:0]    m0123;
    logic [LEVEL_W-1:0]    m456;
    logic [LEVEL_W-1:0]    peak;
    logic [LEVEL_W-1:0]    pick_lo;
    logic [LEVEL_W-1:0]    pick_hi;
    logic [DIV_W-1:0]      pick_rem;
    merge_t                merge_next;
    merge_t                merge_reg;

    function automatic logic [LEVEL_W-1:0] max2(input logic [LEVEL_W-1:0] a,
                                                input logic [LEVEL_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    assign m01   = max2(lanes[0].masked, lanes[1].masked);
    assign m23   = max2(lanes[2].masked, lanes[3].masked);
    assign m45   = max2(lanes[4].masked, lanes[5].masked);
    assign m0123 = max2(m01, m23);
    assign m456  = max2(m45, lanes[6].masked);
    assign peak  = max2(m0123, m456);

    // The trial flags form a thermometer; its top set lane is the quotient.
    always_comb
    begin
        pick_lo  = '0;
        pick_hi  = '0;
        pick_rem = '0;
        for (int k = 0; k < BAND_COUNT - 1; k++)
        begin
            sel[k] = lanes[k].ge & ~lanes[k+1].ge;
            if (sel[k])
            begin
                pick_lo  = pick_lo | lanes[k].band;
                pick_hi  = pick_hi | lanes[k+1].band;
                pick_rem = pick_rem | lanes[k].diff[DIV_W-1:0];
            end
        end
    end

    always_comb
    begin
        merge_next.use_div     = 1'b0;
        merge_next.fixed_level = '0;
        merge_next.band_lo     = pick_lo;
        merge_next.band_hi     = pick_hi;
        merge_next.rem         = pick_rem;
        merge_next.divisor     = divisor;
        unique case (mode)
            MODE_ZERO:
            begin
                merge_next.fixed_level = '0;
            end
            MODE_MAX:
            begin
                merge_next.fixed_level = peak;
            end
            MODE_INTERP:
            begin
                // The last strip lands exactly on the top band.
                if (lanes[BAND_COUNT-1].ge)
                begin
                    merge_next.fixed_level = lanes[BAND_COUNT-1].band;
                end
                else
                begin
                    merge_next.use_div = 1'b1;
                end
            end
            default:
            begin
                merge_next.fixed_level = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            merge_reg <= merge_next;
        end
    end

    assign merge_out = merge_reg;

endmodule

FILE: design/abtsl_div_stage.sv
// One restoring division step that settles a single quotient bit.
// Depends on abtsl_pkg.
module abtsl_div_stage #(
    parameter int BIT = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  abtsl_pkg::div_t  div_in,
    output logic             out_valid,
    output abtsl_pkg::div_t  div_out
);
    import abtsl_pkg::*;

    logic [REM_W-1:0] shifted;
    div_t             div_next;
    div_t             div_reg;
    logic             valid_reg;

    assign shifted = {{(REM_W-DIV_W){1'b0}}, div_in.divisor} << BIT;

    always_comb
    begin
        div_next = div_in;
        if (div_in.rem >= shifted)
        begin
            div_next.rem       = div_in.rem - shifted;
            div_next.quot[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign div_out   = div_reg;

endmodule

FILE: design/abtsl_checker.sv
// Port-level checker for the band to strip level block, bound to the top level.
// Depends on abtsl_pkg and audio_band_to_strip_level_top.
module abtsl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [abtsl_pkg::LEVEL_W-1:0] m_tdata
);
    import abtsl_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] pending_reg;
    logic [CNT_W-1:0] pending_next;

    // Transactions taken in but not yet delivered.
    always_comb
    begin
        pending_next = pending_reg;
        if (s_tvalid && s_tready)
        begin
            pending_next = pending_next + CNT_W'(1);
        end
        if (m_tvalid && m_tready)
        begin
            pending_next = pending_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output slot");

    a_result_has_origin: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != '0)
        else $error("result shown with no transaction in flight");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more transactions in flight than pipeline stages");

endmodule

bind audio_band_to_strip_level_top abtsl_checker u_abtsl_checker (.*);

FILE: bench/audio_band_to_strip_level_top_tb.sv
// Self-checking bench for audio_band_to_strip_level_top: queued stream stimulus, random
// handshake gaps and a built-in level predictor checked against every result transaction.
// Depends on abtsl_pkg and the block's RTL; needs no other file.
`timescale 1ns / 100ps

module audio_band_to_strip_level_top_tb;

    import abtsl_pkg::*;

    localparam int MAX_STRIPS   = MAX_STRIPS_DEF;
    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SHOWN_ERRORS = 10;

    // Register indexes that the block does not decode; writes to them must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED    = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_TOP_INDEX = CFG_INDEX_W'(255);

    // First and last band owned by each strip when there are seven strips or fewer.
    // Row is the strip count minus one, column the strip.
    localparam int FIRST_BAND [7][7] = '{
        '{0, 0, 0, 0, 0, 0, 0},
        '{0, 4, 0, 0, 0, 0, 0},
        '{0, 2, 5, 0, 0, 0, 0},
        '{0, 2, 4, 6, 0, 0, 0},
        '{0, 2, 3, 4, 5, 0, 0},
        '{0, 1, 2, 3, 4, 5, 0},
        '{0, 1, 2, 3, 4, 5, 6}
    };
    localparam int LAST_BAND [7][7] = '{
        '{6, 0, 0, 0, 0, 0, 0},
        '{3, 6, 0, 0, 0, 0, 0},
        '{1, 4, 6, 0, 0, 0, 0},
        '{1, 3, 5, 6, 0, 0, 0},
        '{1, 2, 3, 4, 6, 0, 0},
        '{0, 1, 2, 3, 4, 6, 0},
        '{0, 1, 2, 3, 4, 5, 6}
    };

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [LEVEL_W-1:0]     m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Copy of the block's registers as the bench expects them to be.
    logic [NUM_STRIPS_W-1:0] shadow_strips = NUM_STRIPS_W'(1);
    logic [LEDS_W-1:0]       shadow_leds   = LEDS_W'(1);

    logic [IN_DATA_W-1:0] pending_queries [$];
    logic [LEVEL_W-1:0]   expected_levels [$];

    logic query_taken = 1'b0;
    bit   steady      = 1'b0;
    int   hold_asked  = 0;
    int   hold_done   = 0;
    int   hold_left   = 0;
    int   cycle_cnt   = 0;
    int   error_cnt   = 0;
    int   checked_cnt = 0;
    int   setting_cnt = 0;

    audio_band_to_strip_level_top #(
        .MAX_STRIPS (MAX_STRIPS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Expected level for one query under the current register copy.
    function automatic logic [LEVEL_W-1:0] strip_level_for(input logic [IN_DATA_W-1:0] word);
        int unsigned n;
        int unsigned s;
        int unsigned d;
        int unsigned q;
        int unsigned r;
        int unsigned band [7];
        logic [LEVEL_W-1:0] level;
        n = shadow_strips;
        if (n > MAX_STRIPS)
            n = MAX_STRIPS;
        s = word[STRIP_W-1:0];
        for (int i = 0; i < BAND_COUNT; i++)
            band[i] = word[STRIP_W + LEVEL_W*i +: LEVEL_W];
        level = '0;
        if (n == 0 || shadow_leds == 0 || s >= n)
            return level;
        if (n <= BAND_COUNT)
        begin
            // Largest level over the strip's own band range.
            for (int b = FIRST_BAND[n-1][s]; b <= LAST_BAND[n-1][s]; b++)
                if (band[b] > level)
                    level = LEVEL_W'(band[b]);
        end
        else
        begin
            // Scale the strip onto the band axis and blend the two neighbors.
            d = n - 1;
            q = (s * (BAND_COUNT - 1)) / d;
            r = (s * (BAND_COUNT - 1)) % d;
            if (q + 1 >= BAND_COUNT)
                level = LEVEL_W'(band[BAND_COUNT-1]);
            else
                level = LEVEL_W'((band[q] * (d - r) + band[q+1] * r) / d);
        end
        return level;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_query(input logic [STRIP_W-1:0] s,
                                                        input logic [LEVEL_W-1:0] b [7]);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[STRIP_W-1:0] = s;
        for (int i = 0; i < BAND_COUNT; i++)
            word[STRIP_W + LEVEL_W*i +: LEVEL_W] = b[i];
        return word;
    endfunction

    // Band levels lean toward the extremes so the max and blend paths see them often.
    function automatic logic [LEVEL_W-1:0] random_band();
        int unsigned pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return LEVEL_W'($urandom_range(255));
    endfunction

    function automatic int effective_strips();
        return (shadow_strips > MAX_STRIPS) ? MAX_STRIPS : int'(shadow_strips);
    endfunction

    // Sender: offers the oldest pending query; a taken transaction is replaced right away
    // unless a random gap falls on this cycle.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || query_taken)
        begin
            if (pending_queries.size() != 0 && (steady || $urandom_range(99) >= 10))
            begin
                s_tdata  <= pending_queries.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request so the pipeline
    // backs up and s_tready has to drop.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_done != hold_asked)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_done + 1;
        end
        else
            m_tready <= steady || ($urandom_range(99) >= 10);
    end

    // Monitor: checks each result transaction against the oldest expected level, then
    // records the expectation for a query taken at this edge.
    always @(posedge clk)
    begin
        if (!rst_n)
            query_taken <= 1'b0;
        else
        begin
            query_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (expected_levels.size() == 0)
                begin
                    error_cnt++;
                    if (error_cnt <= SHOWN_ERRORS)
                        $display("strip_level %0d arrived with no query outstanding", m_tdata);
                end
                else
                begin
                    logic [LEVEL_W-1:0] want;
                    want = expected_levels.pop_front();
                    checked_cnt++;
                    if (m_tdata !== want)
                    begin
                        error_cnt++;
                        if (error_cnt <= SHOWN_ERRORS)
                            $display("strip_level mismatch at cycle %0d: expected %0d, got %0d",
                                     cycle_cnt, want, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_levels.push_back(strip_level_for(s_tdata));
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("audio_band_to_strip_level_top_tb: done, errors");
        $finish;
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        if (idx == REG_NUM_STRIPS)
            shadow_strips = val[NUM_STRIPS_W-1:0];
        else if (idx == REG_LEDS_PER_STRIP)
            shadow_leds = val[LEDS_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Holds the sender back until every query has been answered and the pipe is empty.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_queries.size() != 0 || s_tvalid || expected_levels.size() != 0);
        repeat (PIPE_DEPTH + 2) @(negedge clk);
    endtask

    task automatic queue_query(input logic [STRIP_W-1:0] s, input logic [LEVEL_W-1:0] b [7]);
        pending_queries.push_back(pack_query(s, b));
    endtask

    // One register setting: edge strips with a rising ramp, then random queries.
    task automatic run_setting(input logic [CFG_DATA_W-1:0] strips,
                               input logic [CFG_DATA_W-1:0] leds,
                               input int count, input bit no_gaps, input bit long_hold);
        logic [LEVEL_W-1:0] b [7];
        int n_eff;
        wait_idle();
        write_reg(REG_NUM_STRIPS, strips);
        write_reg(REG_LEDS_PER_STRIP, leds);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(REG_TOP_INDEX, CFG_DATA_W'($urandom));
        setting_cnt++;
        steady = no_gaps;
        n_eff  = effective_strips();
        for (int i = 0; i < BAND_COUNT; i++)
            b[i] = LEVEL_W'(i * 40 + 15);
        queue_query('0, b);
        queue_query(STRIP_W'((n_eff == 0) ? 0 : n_eff - 1), b);
        queue_query(STRIP_W'(n_eff), b);
        for (int k = 0; k < count; k++)
        begin
            logic [STRIP_W-1:0] s;
            if (n_eff > 0 && $urandom_range(3) != 0)
                s = STRIP_W'($urandom_range(n_eff - 1));
            else
                s = STRIP_W'($urandom_range(127));
            for (int i = 0; i < BAND_COUNT; i++)
                b[i] = random_band();
            queue_query(s, b);
        end
        if (long_hold)
            hold_asked++;
    endtask

    initial
    begin
        logic [LEVEL_W-1:0] b [7];
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset registers: one strip spanning all seven bands.
        setting_cnt = 1;
        for (int i = 0; i < BAND_COUNT; i++)
            b[i] = '0;
        queue_query('0, b);
        for (int i = 0; i < BAND_COUNT; i++)
            b[i] = '1;
        queue_query('0, b);
        queue_query(STRIP_W'(1), b);
        queue_query('1, b);
        // A single loud band at each position must win the maximum.
        for (int p = 0; p < BAND_COUNT; p++)
        begin
            for (int i = 0; i < BAND_COUNT; i++)
                b[i] = (i == p) ? 8'd255 : 8'd0;
            queue_query('0, b);
        end

        // Disabled block, zero LEDs, each fixed table row, then interpolation and
        // saturation of the strip count, including a write whose upper bits are dropped.
        run_setting(CFG_DATA_W'(0),    CFG_DATA_W'(1),    30, 1'b0, 1'b0);
        run_setting(CFG_DATA_W'(1),    CFG_DATA_W'(0),    30, 1'b0, 1'b0);
        run_setting(CFG_DATA_W'(1),    CFG_DATA_W'(1024), 60, 1'b0, 1'b0);
        run_setting(CFG_DATA_W'(2),    CFG_DATA_W'(1),    80, 1'b0, 1'b0);
        run_setting(CFG_DATA_W'(3),    CFG_DATA_W'(500),  80, 1'b0, 1'b0);
        run_setting(CFG_DATA_W'(4),    CFG_DATA_W'(7),    80, 1'b0, 1'b0);
        run_setting(CFG_DATA_W'(5),    CFG_DATA_W'(2047), 80, 1'b0, 1'b0);
        run_setting(CFG_DATA_W'(6),    CFG_DATA_W'(3),    80, 1'b0, 1'b0);
        run_setting(CFG_DATA_W'(7),    CFG_DATA_W'(1),    80, 1'b0, 1'b0);
        run_setting(CFG_DATA_W'(8),    CFG_DATA_W'(1),   100, 1'b1, 1'b0);
        run_setting(CFG_DATA_W'(13),   CFG_DATA_W'(9),    90, 1'b0, 1'b0);
        run_setting(CFG_DATA_W'(33),   CFG_DATA_W'(100),  90, 1'b0, 1'b0);
        run_setting(CFG_DATA_W'(64),   CFG_DATA_W'(1024),120, 1'b0, 1'b1);
        run_setting(CFG_DATA_W'(65),   CFG_DATA_W'(1),    60, 1'b0, 1'b0);
        run_setting(CFG_DATA_W'(127),  CFG_DATA_W'(1),    80, 1'b0, 1'b0);
        run_setting(CFG_DATA_W'(1224), CFG_DATA_W'(1),    60, 1'b0, 1'b0);
        run_setting(CFG_DATA_W'(63),   CFG_DATA_W'(1),    80, 1'b0, 1'b0);

        wait_idle();
        $display("Checked %0d strip level results over %0d register settings, from disabled",
                 checked_cnt, setting_cnt);
        $display("and single-strip cases through fixed band ranges to saturated interpolation.");
        if (error_cnt == 0 && expected_levels.size() == 0)
            $display("audio_band_to_strip_level_top_tb: done, clean");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", error_cnt,
                     expected_levels.size());
            $display("audio_band_to_strip_level_top_tb: done, errors");
        end
        $finish;
    end

endmodule
